// ----- rtl/dtf_pkg.sv -----
// Shared constants and types for the degenerate triangle filter.
// No dependencies; every rtl file imports this package.
package dtf_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int INDEX_BITS_DEF = 20;

    // Squared-length datapath: 64-bit saturating, 32-bit square inputs
    localparam int AREA_W = 64;
    localparam int SQ_W   = 32;

    localparam logic [AREA_W-1:0] THRESH_RESET = 64'd1;

    typedef enum logic [1:0] {
        REASON_KEEP = 2'd0,
        REASON_DUP  = 2'd1,
        REASON_AREA = 2'd2
    } reason_t;

endpackage

// ----- rtl/degenerate_triangle_filter.sv -----
// Top level of the degenerate triangle filter: stream ports, threshold register,
// index delay line and verdict stage. Depends on dtf_pkg, dtf_edge, dtf_cross, dtf_norm.
//
// Usage:
//   One triangle enters per word on the s_axis channel: three vertex indices and the
//   three vertices' signed fixed-point coordinates. One verdict word leaves per
//   triangle on m_axis, in input order: keep and reason on tuser, the three indices
//   passed through on tdata. A triangle with any two equal indices is dropped with
//   reason DUP; otherwise the squared length of (B-A) x (C-A) is compared against
//   area_threshold and the triangle is dropped with reason AREA if it falls below.
//   Squares and sums saturate at 2^64-1.
//   Stages from input accept to output valid: edge, products, cross, magnitude,
//   square, two adds, compare. Throughput: one word per cycle while output words are
//   taken; the rate is set by the eight-stage pipeline, which advances as a whole.
//   Stall: when m_axis_tready is low with a valid word in the output register, the
//   whole pipeline holds and s_axis_tready drops in the same cycle; no word is lost
//   or repeated. A free output register lets the pipeline keep moving.
//   Reset: rst_n clears all valid bits and sets area_threshold to 1, so only
//   triangles of zero area are dropped for area. Write cfg_* only while idle.
module degenerate_triangle_filter #(
    parameter int COORD_BITS = dtf_pkg::COORD_BITS_DEF,
    parameter int INDEX_BITS = dtf_pkg::INDEX_BITS_DEF
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    // lsb up: index_a, index_b, index_c, ax, ay, az, bx, by, bz, cx, cy, cz, zero pad
    input  logic [((3*INDEX_BITS+9*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  logic                                         s_axis_tvalid,
    output logic                                         s_axis_tready,
    // lsb up: out_index_a, out_index_b, out_index_c, zero pad
    output logic [((3*INDEX_BITS+7)/8)*8-1:0]            m_axis_tdata,
    // lsb up: keep, reason[1:0]
    output logic [2:0]                                   m_axis_tuser,
    output logic                                         m_axis_tvalid,
    input  logic                                         m_axis_tready,
    input  logic                                         cfg_we,
    input  logic [dtf_pkg::AREA_W-1:0]                   cfg_wdata
);
    import dtf_pkg::*;

    localparam int CB      = COORD_BITS;
    localparam int IB      = INDEX_BITS;
    localparam int OUT_W   = ((3 * IB + 7) / 8) * 8;
    localparam int NW      = 2 * CB + 3;
    localparam int SIDE_W  = 3 * IB + 1;
    // Indices and dup flag ride alongside stages 2 to 7
    localparam int SIDE_DEPTH = 6;

    logic                 advance;

    // Threshold register
    logic [AREA_W-1:0]    area_threshold_reg;

    // Stage outputs
    logic                 edge_valid;
    logic [SIDE_W-1:0]    edge_side;
    logic signed [CB:0]   e1x, e1y, e1z, e2x, e2y, e2z;
    logic                 cross_valid;
    logic signed [NW-1:0] nx, ny, nz;
    logic                 norm_valid;
    logic [AREA_W-1:0]    norm_sq;

    logic [SIDE_W-1:0]    side_reg [SIDE_DEPTH];

    // Output register
    logic                 out_valid_reg;
    logic                 keep_reg;
    reason_t              reason_reg;
    logic [3*IB-1:0]      index_reg;
    reason_t              reason_next;

    // Advance the whole pipeline unless a finished word is stuck at the output
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            area_threshold_reg <= THRESH_RESET;
        end
        else if (cfg_we)
        begin
            area_threshold_reg <= cfg_wdata;
        end
    end

    dtf_edge #(
        .COORD_BITS (CB),
        .INDEX_BITS (IB)
    ) u_edge (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (s_axis_tvalid),
        .index_a   (s_axis_tdata[0 +: IB]),
        .index_b   (s_axis_tdata[IB +: IB]),
        .index_c   (s_axis_tdata[2*IB +: IB]),
        .ax        (s_axis_tdata[3*IB + 0*CB +: CB]),
        .ay        (s_axis_tdata[3*IB + 1*CB +: CB]),
        .az        (s_axis_tdata[3*IB + 2*CB +: CB]),
        .bx        (s_axis_tdata[3*IB + 3*CB +: CB]),
        .by        (s_axis_tdata[3*IB + 4*CB +: CB]),
        .bz        (s_axis_tdata[3*IB + 5*CB +: CB]),
        .cx        (s_axis_tdata[3*IB + 6*CB +: CB]),
        .cy        (s_axis_tdata[3*IB + 7*CB +: CB]),
        .cz        (s_axis_tdata[3*IB + 8*CB +: CB]),
        .out_valid (edge_valid),
        .side      (edge_side),
        .e1x       (e1x),
        .e1y       (e1y),
        .e1z       (e1z),
        .e2x       (e2x),
        .e2y       (e2y),
        .e2z       (e2z)
    );

    dtf_cross #(
        .COORD_BITS (CB)
    ) u_cross (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (edge_valid),
        .e1x       (e1x),
        .e1y       (e1y),
        .e1z       (e1z),
        .e2x       (e2x),
        .e2y       (e2y),
        .e2z       (e2z),
        .out_valid (cross_valid),
        .nx        (nx),
        .ny        (ny),
        .nz        (nz)
    );

    dtf_norm #(
        .COORD_BITS (CB)
    ) u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (cross_valid),
        .nx        (nx),
        .ny        (ny),
        .nz        (nz),
        .out_valid (norm_valid),
        .norm_sq   (norm_sq)
    );

    // Hold indices and dup flag in step with the arithmetic stages
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            side_reg[0] <= edge_side;
            for (int i = 1; i < SIDE_DEPTH; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // Repeated index wins; the area is only looked at for distinct indices
    always_comb
    begin
        if (side_reg[SIDE_DEPTH-1][0])
        begin
            reason_next = REASON_DUP;
        end
        else if (norm_sq < area_threshold_reg)
        begin
            reason_next = REASON_AREA;
        end
        else
        begin
            reason_next = REASON_KEEP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= norm_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            reason_reg <= reason_next;
            keep_reg   <= (reason_next == REASON_KEEP);
            index_reg  <= side_reg[SIDE_DEPTH-1][SIDE_W-1:1];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'(index_reg);
    assign m_axis_tuser  = {reason_reg, keep_reg};

    // A ready sink never stalls the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output was ready");

    // Keep flag and reason code agree
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser[0] == (m_axis_tuser[2:1] == REASON_KEEP)))
    else $error("keep flag disagrees with reason");

    // Indices seen at the output that repeat must carry the repeated-index reason
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && ((index_reg[0 +: IB] == index_reg[IB +: IB])
                        || (index_reg[IB +: IB] == index_reg[2*IB +: IB])
                        || (index_reg[0 +: IB] == index_reg[2*IB +: IB])))
        |-> (m_axis_tuser[2:1] == REASON_DUP))
    else $error("repeated index not flagged");

    // Distinct indices never get the repeated-index reason
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser[2:1] == REASON_DUP))
        |-> ((index_reg[0 +: IB] == index_reg[IB +: IB])
          || (index_reg[IB +: IB] == index_reg[2*IB +: IB])
          || (index_reg[0 +: IB] == index_reg[2*IB +: IB])))
    else $error("distinct indices flagged as repeated");

    // A zero threshold drops nothing for area
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (area_threshold_reg == '0)) |-> (m_axis_tuser[2:1] != REASON_AREA))
    else $error("area drop with zero threshold");

endmodule

// ----- rtl/dtf_edge.sv -----
// Stage 1: edge vectors from the first vertex and the repeated-index check.
// Depends on dtf_pkg.
module dtf_edge #(
    parameter int COORD_BITS = dtf_pkg::COORD_BITS_DEF,
    parameter int INDEX_BITS = dtf_pkg::INDEX_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         advance,
    input  logic                         in_valid,
    input  logic        [INDEX_BITS-1:0] index_a,
    input  logic        [INDEX_BITS-1:0] index_b,
    input  logic        [INDEX_BITS-1:0] index_c,
    input  logic signed [COORD_BITS-1:0] ax,
    input  logic signed [COORD_BITS-1:0] ay,
    input  logic signed [COORD_BITS-1:0] az,
    input  logic signed [COORD_BITS-1:0] bx,
    input  logic signed [COORD_BITS-1:0] by,
    input  logic signed [COORD_BITS-1:0] bz,
    input  logic signed [COORD_BITS-1:0] cx,
    input  logic signed [COORD_BITS-1:0] cy,
    input  logic signed [COORD_BITS-1:0] cz,
    output logic                         out_valid,
    output logic      [3*INDEX_BITS:0]   side,       // {index_c, index_b, index_a, dup}
    output logic signed [COORD_BITS:0]   e1x,
    output logic signed [COORD_BITS:0]   e1y,
    output logic signed [COORD_BITS:0]   e1z,
    output logic signed [COORD_BITS:0]   e2x,
    output logic signed [COORD_BITS:0]   e2y,
    output logic signed [COORD_BITS:0]   e2z
);
    import dtf_pkg::*;

    localparam int EW = COORD_BITS + 1;

    logic                 valid_reg;
    logic [3*INDEX_BITS:0] side_reg;
    logic signed [EW-1:0] e1x_reg, e1y_reg, e1z_reg;
    logic signed [EW-1:0] e2x_reg, e2y_reg, e2z_reg;
    logic                 dup;

    assign dup = (index_a == index_b) || (index_b == index_c) || (index_a == index_c);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            side_reg <= {index_c, index_b, index_a, dup};
            e1x_reg  <= EW'(bx) - EW'(ax);
            e1y_reg  <= EW'(by) - EW'(ay);
            e1z_reg  <= EW'(bz) - EW'(az);
            e2x_reg  <= EW'(cx) - EW'(ax);
            e2y_reg  <= EW'(cy) - EW'(ay);
            e2z_reg  <= EW'(cz) - EW'(az);
        end
    end

    assign out_valid = valid_reg;
    assign side      = side_reg;
    assign e1x       = e1x_reg;
    assign e1y       = e1y_reg;
    assign e1z       = e1z_reg;
    assign e2x       = e2x_reg;
    assign e2y       = e2y_reg;
    assign e2z       = e2z_reg;

endmodule

// ----- rtl/dtf_cross.sv -----
// Stages 2 and 3: six partial products, then the cross product components.
// Depends on dtf_pkg.
module dtf_cross #(
    parameter int COORD_BITS = dtf_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         advance,
    input  logic                         in_valid,
    input  logic signed [COORD_BITS:0]   e1x,
    input  logic signed [COORD_BITS:0]   e1y,
    input  logic signed [COORD_BITS:0]   e1z,
    input  logic signed [COORD_BITS:0]   e2x,
    input  logic signed [COORD_BITS:0]   e2y,
    input  logic signed [COORD_BITS:0]   e2z,
    output logic                         out_valid,
    output logic signed [2*COORD_BITS+2:0] nx,
    output logic signed [2*COORD_BITS+2:0] ny,
    output logic signed [2*COORD_BITS+2:0] nz
);
    import dtf_pkg::*;

    localparam int PW = 2 * COORD_BITS + 2;
    localparam int NW = PW + 1;

    logic                 p_valid_reg;
    logic                 n_valid_reg;
    logic signed [PW-1:0] p_yz_reg, p_zy_reg, p_zx_reg, p_xz_reg, p_xy_reg, p_yx_reg;
    logic signed [NW-1:0] nx_reg, ny_reg, nz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            n_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            p_valid_reg <= in_valid;
            n_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p_yz_reg <= PW'(e1y) * PW'(e2z);
            p_zy_reg <= PW'(e1z) * PW'(e2y);
            p_zx_reg <= PW'(e1z) * PW'(e2x);
            p_xz_reg <= PW'(e1x) * PW'(e2z);
            p_xy_reg <= PW'(e1x) * PW'(e2y);
            p_yx_reg <= PW'(e1y) * PW'(e2x);
            nx_reg   <= NW'(p_yz_reg) - NW'(p_zy_reg);
            ny_reg   <= NW'(p_zx_reg) - NW'(p_xz_reg);
            nz_reg   <= NW'(p_xy_reg) - NW'(p_yx_reg);
        end
    end

    assign out_valid = n_valid_reg;
    assign nx        = nx_reg;
    assign ny        = ny_reg;
    assign nz        = nz_reg;

endmodule

// ----- rtl/dtf_norm.sv -----
// Stages 4 to 7: magnitude, saturating square and saturating sum of |N|^2.
// Depends on dtf_pkg.
module dtf_norm #(
    parameter int COORD_BITS = dtf_pkg::COORD_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           advance,
    input  logic                           in_valid,
    input  logic signed [2*COORD_BITS+2:0] nx,
    input  logic signed [2*COORD_BITS+2:0] ny,
    input  logic signed [2*COORD_BITS+2:0] nz,
    output logic                           out_valid,
    output logic [dtf_pkg::AREA_W-1:0]     norm_sq
);
    import dtf_pkg::*;

    localparam int NW = 2 * COORD_BITS + 3;
    localparam int MW = (NW > SQ_W) ? NW : SQ_W + 1;
    localparam int LANES = 3;

    function automatic logic [AREA_W-1:0] sat_add(input logic [AREA_W-1:0] x,
                                                  input logic [AREA_W-1:0] y);
        logic [AREA_W:0] s;
        s = {1'b0, x} + {1'b0, y};
        return s[AREA_W] ? '1 : s[AREA_W-1:0];
    endfunction

    logic signed [NW-1:0] n_in [LANES];
    logic [NW-1:0]        mag [LANES];
    logic [MW-1:0]        mag_ext [LANES];

    logic [3:0]           valid_reg;
    logic [SQ_W-1:0]      mag_reg [LANES];
    logic [LANES-1:0]     big_reg;
    logic [AREA_W-1:0]    sq_reg [LANES];
    logic [AREA_W-1:0]    s01_reg;
    logic [AREA_W-1:0]    sq2_reg;
    logic [AREA_W-1:0]    sum_reg;

    assign n_in[0] = nx;
    assign n_in[1] = ny;
    assign n_in[2] = nz;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            mag[i]     = n_in[i][NW-1] ? NW'(-n_in[i]) : NW'(n_in[i]);
            mag_ext[i] = MW'(mag[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                // Any magnitude of 2^32 or more squares past the 64-bit range
                mag_reg[i] <= mag_ext[i][SQ_W-1:0];
                big_reg[i] <= |mag_ext[i][MW-1:SQ_W];
                sq_reg[i]  <= big_reg[i] ? '1 : AREA_W'(mag_reg[i]) * AREA_W'(mag_reg[i]);
            end
            s01_reg <= sat_add(sq_reg[0], sq_reg[1]);
            sq2_reg <= sq_reg[2];
            sum_reg <= sat_add(s01_reg, sq2_reg);
        end
    end

    assign out_valid = valid_reg[3];
    assign norm_sq   = sum_reg;

endmodule
